// ----- rtl/core/qvr_pkg.sv -----
// Shared constants for the quaternion vector rotation block.
// No dependencies; used by the multiplier and the top level.
package qvr_pkg;

    // Width of one limb of a split multiplication (one hard multiplier input).
    localparam int LIMB_W = 32;

    // Pipeline registers a beat passes besides the divider stages, in order:
    // front multipliers, combine, back multipliers, sum, magnitude, dividend set-up
    // and the final clamp.
    localparam int FIXED_STAGES = 9;

endpackage

// ----- rtl/core/qvr_if.sv -----
// Stream interfaces of the quaternion vector rotation block.
// One interface for the input beat and one for the result beat; no dependencies.
interface qvr_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] quat_w;
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;
    logic signed [W-1:0] vec_x;
    logic signed [W-1:0] vec_y;
    logic signed [W-1:0] vec_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                    output ready);
endinterface

interface qvr_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rot_x;
    logic signed [W-1:0] rot_y;
    logic signed [W-1:0] rot_z;
    logic                zero_quat;
    logic                overflow;

    modport source (output valid, rot_x, rot_y, rot_z, zero_quat, overflow, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, zero_quat, overflow, output ready);
endinterface

// ----- rtl/core/qvr_mul.sv -----
// Two-stage signed multiplier built from limb-sized partial products.
// Depends on qvr_pkg for the limb width.
module qvr_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [AW-1:0]  i_a,
    input  logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int LW = qvr_pkg::LIMB_W;
    localparam int NA = (AW + LW - 1) / LW;
    localparam int NB = (BW + LW - 1) / LW;
    localparam int PW = (NA + NB) * LW;

    logic signed [NA*LW-1:0]   a_ext;
    logic signed [NB*LW-1:0]   b_ext;
    logic signed [LW:0]        a_limb [NA];
    logic signed [LW:0]        b_limb [NB];
    logic signed [2*LW+1:0]    r_pp [NA][NB];
    logic signed [PW-1:0]      pp_sum;
    logic signed [AW+BW-1:0]   r_p;

    assign a_ext = (NA*LW)'(i_a);
    assign b_ext = (NB*LW)'(i_b);

    // Lower limbs are unsigned, the top limb carries the sign.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                a_limb[i] = {a_ext[i*LW+LW-1], a_ext[i*LW +: LW]};
            end else begin
                a_limb[i] = {1'b0, a_ext[i*LW +: LW]};
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                b_limb[j] = {b_ext[j*LW+LW-1], b_ext[j*LW +: LW]};
            end else begin
                b_limb[j] = {1'b0, b_ext[j*LW +: LW]};
            end
        end
    end

    // First stage: one limb product per hard multiplier.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= a_limb[i] * b_limb[j];
                end
            end
        end
    end

    // Second stage: align and add the partial products.
    always_comb begin
        pp_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                pp_sum = pp_sum + (PW'(r_pp[i][j]) <<< (LW * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= pp_sum[AW+BW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/qvr_scale.sv -----
// One output coordinate: sums the numerator terms, divides by the squared length
// with rounding, and clamps to the output width. Uses no package items.
module qvr_scale #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [3*W+1:0] i_p0,
    input  logic signed [3*W+2:0] i_p1,
    input  logic signed [3*W+1:0] i_p2,
    input  logic        [2*W:0]   i_n,
    output logic signed [W-1:0]   o_rot,
    output logic                  o_sat
);
    localparam int NW  = 3 * W + 5;   // signed numerator
    localparam int NRW = 2 * W + 1;   // squared length
    localparam int DRW = NRW + 1;     // divisor, twice the squared length
    localparam int DW  = NW + 2;      // dividend

    logic signed [NW-1:0]  r_num;
    logic        [NRW-1:0] r_n1;
    logic        [NW-1:0]  r_mag;
    logic        [NRW-1:0] r_n2;
    logic                  r_neg2;
    logic        [DW-1:0]  r_rem [0:W];
    logic        [DRW-1:0] r_den [0:W];
    logic        [W-1:0]   r_q   [0:W];
    logic                  r_neg [0:W];
    logic                  r_over[0:W];
    logic        [W-1:0]   lim;
    logic        [W-1:0]   mag_out;
    logic                  sat;
    logic signed [W-1:0]   r_rot;
    logic                  r_sat;

    // Sum of the three product terms.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= NW'(i_p0) + NW'(i_p1) + NW'(i_p2);
            r_n1  <= i_n;
        end
    end

    // Sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2 <= r_num[NW-1];
            r_mag  <= r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
            r_n2   <= r_n1;
        end
    end

    // Rounded dividend 2|num| + n over divisor 2n.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DW'({r_mag, 1'b0}) + DW'(r_n2);
            r_den[0]  <= {r_n2, 1'b0};
            r_q[0]    <= '0;
            r_neg[0]  <= r_neg2;
            r_over[0] <= 1'b0;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    // The first stage also flags a quotient that needs more than W bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                logic [DW:0] diff;
                diff = {1'b0, r_rem[k]} - ((DW+1)'(r_den[k]) << (W - 1 - k));
                if (!diff[DW]) begin
                    r_rem[k+1] <= diff[DW-1:0];
                    r_q[k+1]   <= r_q[k] | (W'(1) << (W - 1 - k));
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1]   <= r_q[k];
                end
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                if (k == 0) begin
                    r_over[k+1] <= (DW+1)'(r_rem[k]) >= ((DW+1)'(r_den[k]) << W);
                end else begin
                    r_over[k+1] <= r_over[k];
                end
            end
        end
    end

    // Clamp to the signed range and restore the sign.
    always_comb begin
        lim     = r_neg[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
        sat     = r_over[W] || (r_q[W] > lim);
        mag_out = sat ? lim : r_q[W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= r_neg[W] ? -mag_out : mag_out;
            r_sat <= sat;
        end
    end

    assign o_rot = r_rot;
    assign o_sat = r_sat;

endmodule

// ----- rtl/core/quaternion_vector_rotate_top.sv -----
// Quaternion vector rotation top level: pipelined datapath and flow control.
// Depends on qvr_pkg, qvr_if, qvr_mul and qvr_scale.
//
// Rotates a signed Q16.16 vector by a signed Q8.24 quaternion, normalised by
// its squared length, with one rounding (to nearest, ties away from zero) and
// saturation. A beat can be taken every clock cycle unless a result waits unread
// at the output; the depth of the pipeline is set mainly by the restoring divider,
// which produces one quotient bit per stage. An all-zero quaternion passes the
// vector through with zero_quat set. The whole pipeline holds while a result
// waits at the output.
module quaternion_vector_rotate_top #(
    parameter int COMP_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    qvr_in_if.sink          i_in,
    qvr_out_if.source       o_out
);
    localparam int W   = COMP_WIDTH;
    localparam int L   = W + qvr_pkg::FIXED_STAGES;
    localparam int PW  = 2 * W;
    localparam int NRW = 2 * W + 1;
    localparam int SW  = 2 * W + 2;
    localparam int D2W = 2 * W + 3;
    localparam int CW  = 2 * W + 1;

    logic                 en;
    logic [L-1:0]         r_vld;
    logic                 r_zero [0:L-1];
    logic signed [W-1:0]  r_vx [0:L-1];
    logic signed [W-1:0]  r_vy [0:L-1];
    logic signed [W-1:0]  r_vz [0:L-1];
    logic signed [W-1:0]  r_qw [0:2];
    logic signed [W-1:0]  r_qx [0:2];
    logic signed [W-1:0]  r_qy [0:2];
    logic signed [W-1:0]  r_qz [0:2];

    logic signed [PW-1:0] ww, xx, yy, zz, xa, yb, zc, yc, zb, za, xc, xb, ya;
    logic        [NRW-1:0] r_n;
    logic signed [SW-1:0]  r_s;
    logic signed [D2W-1:0] r_d2;
    logic signed [W:0]     r_w2;
    logic signed [CW-1:0]  r_cx, r_cy, r_cz;
    logic        [NRW-1:0] r_nd [0:1];

    logic signed [3*W+1:0] sa, sb, sc, wcx, wcy, wcz;
    logic signed [3*W+2:0] dx, dy, dz;
    logic signed [W-1:0]   rot_x, rot_y, rot_z;
    logic                  sat_x, sat_y, sat_z;

    // The pipeline moves whenever the output register is free or being read.
    assign en         = !r_vld[L-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_in.valid};
        end
    end

    // Side data travelling with each beat.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0] <= (i_in.quat_w == '0) && (i_in.quat_x == '0) &&
                         (i_in.quat_y == '0) && (i_in.quat_z == '0);
            r_vx[0] <= i_in.vec_x;
            r_vy[0] <= i_in.vec_y;
            r_vz[0] <= i_in.vec_z;
            r_qw[0] <= i_in.quat_w;
            r_qx[0] <= i_in.quat_x;
            r_qy[0] <= i_in.quat_y;
            r_qz[0] <= i_in.quat_z;
            for (int k = 1; k < L; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_vx[k]   <= r_vx[k-1];
                r_vy[k]   <= r_vy[k-1];
                r_vz[k]   <= r_vz[k-1];
            end
            for (int k = 1; k < 3; k++) begin
                r_qw[k] <= r_qw[k-1];
                r_qx[k] <= r_qx[k-1];
                r_qy[k] <= r_qy[k-1];
                r_qz[k] <= r_qz[k-1];
            end
        end
    end

    // Front products: squares, dot product terms and cross product terms.
    qvr_mul #(.AW(W), .BW(W)) u_ww (.i_clk, .i_en(en), .i_a(i_in.quat_w), .i_b(i_in.quat_w), .o_p(ww));
    qvr_mul #(.AW(W), .BW(W)) u_xx (.i_clk, .i_en(en), .i_a(i_in.quat_x), .i_b(i_in.quat_x), .o_p(xx));
    qvr_mul #(.AW(W), .BW(W)) u_yy (.i_clk, .i_en(en), .i_a(i_in.quat_y), .i_b(i_in.quat_y), .o_p(yy));
    qvr_mul #(.AW(W), .BW(W)) u_zz (.i_clk, .i_en(en), .i_a(i_in.quat_z), .i_b(i_in.quat_z), .o_p(zz));
    qvr_mul #(.AW(W), .BW(W)) u_xa (.i_clk, .i_en(en), .i_a(i_in.quat_x), .i_b(i_in.vec_x), .o_p(xa));
    qvr_mul #(.AW(W), .BW(W)) u_yb (.i_clk, .i_en(en), .i_a(i_in.quat_y), .i_b(i_in.vec_y), .o_p(yb));
    qvr_mul #(.AW(W), .BW(W)) u_zc (.i_clk, .i_en(en), .i_a(i_in.quat_z), .i_b(i_in.vec_z), .o_p(zc));
    qvr_mul #(.AW(W), .BW(W)) u_yc (.i_clk, .i_en(en), .i_a(i_in.quat_y), .i_b(i_in.vec_z), .o_p(yc));
    qvr_mul #(.AW(W), .BW(W)) u_zb (.i_clk, .i_en(en), .i_a(i_in.quat_z), .i_b(i_in.vec_y), .o_p(zb));
    qvr_mul #(.AW(W), .BW(W)) u_za (.i_clk, .i_en(en), .i_a(i_in.quat_z), .i_b(i_in.vec_x), .o_p(za));
    qvr_mul #(.AW(W), .BW(W)) u_xc (.i_clk, .i_en(en), .i_a(i_in.quat_x), .i_b(i_in.vec_z), .o_p(xc));
    qvr_mul #(.AW(W), .BW(W)) u_xb (.i_clk, .i_en(en), .i_a(i_in.quat_x), .i_b(i_in.vec_y), .o_p(xb));
    qvr_mul #(.AW(W), .BW(W)) u_ya (.i_clk, .i_en(en), .i_a(i_in.quat_y), .i_b(i_in.vec_x), .o_p(ya));

    // Combine into squared length, scalar weight, doubled dot product and cross product.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n  <= NRW'(unsigned'(ww)) + NRW'(unsigned'(xx)) +
                    NRW'(unsigned'(yy)) + NRW'(unsigned'(zz));
            r_s  <= SW'(ww) - SW'(xx) - SW'(yy) - SW'(zz);
            r_d2 <= (D2W'(xa) + D2W'(yb) + D2W'(zc)) <<< 1;
            r_w2 <= (W+1)'(r_qw[1]) <<< 1;
            r_cx <= CW'(yc) - CW'(zb);
            r_cy <= CW'(za) - CW'(xc);
            r_cz <= CW'(xb) - CW'(ya);
        end
    end

    // Keep the length aligned with the back products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nd[0] <= r_n;
            r_nd[1] <= r_nd[0];
        end
    end

    // Back products: s*v + d2*q + 2w*(q x v), per axis.
    qvr_mul #(.AW(SW),  .BW(W))  u_sa (.i_clk, .i_en(en), .i_a(r_s),  .i_b(r_vx[2]), .o_p(sa));
    qvr_mul #(.AW(SW),  .BW(W))  u_sb (.i_clk, .i_en(en), .i_a(r_s),  .i_b(r_vy[2]), .o_p(sb));
    qvr_mul #(.AW(SW),  .BW(W))  u_sc (.i_clk, .i_en(en), .i_a(r_s),  .i_b(r_vz[2]), .o_p(sc));
    qvr_mul #(.AW(D2W), .BW(W))  u_dx (.i_clk, .i_en(en), .i_a(r_d2), .i_b(r_qx[2]), .o_p(dx));
    qvr_mul #(.AW(D2W), .BW(W))  u_dy (.i_clk, .i_en(en), .i_a(r_d2), .i_b(r_qy[2]), .o_p(dy));
    qvr_mul #(.AW(D2W), .BW(W))  u_dz (.i_clk, .i_en(en), .i_a(r_d2), .i_b(r_qz[2]), .o_p(dz));
    qvr_mul #(.AW(W+1), .BW(CW)) u_cx (.i_clk, .i_en(en), .i_a(r_w2), .i_b(r_cx), .o_p(wcx));
    qvr_mul #(.AW(W+1), .BW(CW)) u_cy (.i_clk, .i_en(en), .i_a(r_w2), .i_b(r_cy), .o_p(wcy));
    qvr_mul #(.AW(W+1), .BW(CW)) u_cz (.i_clk, .i_en(en), .i_a(r_w2), .i_b(r_cz), .o_p(wcz));

    // Normalise, round and clamp each coordinate.
    qvr_scale #(.W(W)) u_scale_x (.i_clk, .i_en(en), .i_p0(sa), .i_p1(dx), .i_p2(wcx),
                                  .i_n(r_nd[1]), .o_rot(rot_x), .o_sat(sat_x));
    qvr_scale #(.W(W)) u_scale_y (.i_clk, .i_en(en), .i_p0(sb), .i_p1(dy), .i_p2(wcy),
                                  .i_n(r_nd[1]), .o_rot(rot_y), .o_sat(sat_y));
    qvr_scale #(.W(W)) u_scale_z (.i_clk, .i_en(en), .i_p0(sc), .i_p1(dz), .i_p2(wcz),
                                  .i_n(r_nd[1]), .o_rot(rot_z), .o_sat(sat_z));

    // Result beat; a zero quaternion selects the untouched vector.
    assign o_out.valid     = r_vld[L-1];
    assign o_out.zero_quat = r_zero[L-1];
    assign o_out.rot_x     = r_zero[L-1] ? r_vx[L-1] : rot_x;
    assign o_out.rot_y     = r_zero[L-1] ? r_vy[L-1] : rot_y;
    assign o_out.rot_z     = r_zero[L-1] ? r_vz[L-1] : rot_z;
    assign o_out.overflow  = !r_zero[L-1] && (sat_x || sat_y || sat_z);

endmodule

// ----- rtl/core/qvr_check.sv -----
// Port-level checks for the quaternion vector rotation top level.
// Bound to quaternion_vector_rotate_top; no package dependencies.
module qvr_check #(
    parameter int W = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_rot_x,
    input logic         i_zero_quat,
    input logic         i_overflow
);
    // A waiting result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    // A waiting result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_rot_x) && $stable(i_overflow))
        else $error("result payload changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    // With no result waiting the block must accept.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output");

    // The identity pass-through never saturates.
    a_zero_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_zero_quat && i_overflow))
        else $error("overflow flagged on identity pass-through");

endmodule

bind quaternion_vector_rotate_top qvr_check #(.W(COMP_WIDTH)) u_qvr_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rot_x     (o_out.rot_x),
    .i_zero_quat (o_out.zero_quat),
    .i_overflow  (o_out.overflow)
);
